// ===== sv/wps_pkg.sv =====
// Shared types, codes and step tables for the wash program sequencer.
package wps_pkg;

	// Mode codes
	localparam logic [3:0] MODE_IDLE = 4'd0;
	localparam logic [3:0] MODE_SEL1 = 4'd1;
	localparam logic [3:0] MODE_SEL2 = 4'd2;
	localparam logic [3:0] MODE_SEL3 = 4'd3;
	localparam logic [3:0] MODE_ARM1 = 4'd4;
	localparam logic [3:0] MODE_ARM2 = 4'd5;
	localparam logic [3:0] MODE_ARM3 = 4'd6;
	localparam logic [3:0] MODE_RUN1 = 4'd7;
	localparam logic [3:0] MODE_RUN2 = 4'd8;
	localparam logic [3:0] MODE_RUN3 = 4'd9;

	// Offset from a selected mode to its armed mode, and armed to running
	localparam logic [3:0] MODE_STRIDE = 4'd3;

	// Configuration register indexes
	localparam logic [1:0] REG_TICK_INC  = 2'd0;
	localparam logic [1:0] REG_SPIN_LOW  = 2'd1;
	localparam logic [1:0] REG_SPIN_HIGH = 2'd2;

	localparam int CFG_BITS = 10;
	localparam int DUR_BITS = 14;

	localparam logic [CFG_BITS-1:0] TICK_INC_RST  = 10'd50;
	localparam logic [CFG_BITS-1:0] SPIN_LOW_RST  = 10'd717;
	localparam logic [CFG_BITS-1:0] SPIN_HIGH_RST = 10'd819;

	// LED spin bits (bits 7:6)
	localparam logic [1:0] LED_SPIN_LOW  = 2'b01;
	localparam logic [1:0] LED_SPIN_HIGH = 2'b10;

	typedef struct packed {
		logic spin_on;
		logic spin_off;
		logic prog_three;
		logic prog_two;
		logic prog_one;
		logic start;
	} btn_t;

	typedef struct packed {
		logic [CFG_BITS-1:0] tick_increment_ms;
		logic [CFG_BITS-1:0] spin_low_speed;
		logic [CFG_BITS-1:0] spin_high_speed;
	} cfg_t;

	typedef struct packed {
		logic [3:0]         mode_shown;
		logic [2:0]         step_shown;
		logic [1:0]         program_shown;
		logic [7:0]         led_pattern;
		logic signed [10:0] speed_setpoint;
	} res_t;

	// Number of steps of a program (p = program - 1)
	function automatic logic [2:0] prog_len(input logic [1:0] p);
		logic [2:0] n;
		unique case (p)
			2'd0:    n = 3'd5;
			2'd1:    n = 3'd4;
			default: n = 3'd2;
		endcase
		return n;
	endfunction

	// Step duration in ms
	function automatic logic [DUR_BITS-1:0] step_dur(input logic [1:0] p,
			input logic [2:0] idx);
		logic [DUR_BITS-1:0] d;
		d = '0;
		unique case (p)
			2'd0: begin
				if (idx == 3'd4) d = 14'd10000;
				else if (idx < 3'd4) d = 14'd4000;
			end
			2'd1: begin
				unique case (idx)
					3'd0:    d = 14'd2000;
					3'd1:    d = 14'd4000;
					3'd2:    d = 14'd2000;
					3'd3:    d = 14'd6000;
					default: d = '0;
				endcase
			end
			default: begin
				if (idx < 3'd2) d = 14'd3000;
			end
		endcase
		return d;
	endfunction

	// Step speed, Q3.8 signed; spin steps take the selected spin speed
	function automatic logic signed [10:0] step_speed(input logic [1:0] p,
			input logic [2:0] idx, input logic [CFG_BITS-1:0] spin);
		logic signed [10:0] s;
		logic signed [10:0] sp;
		sp = $signed({1'b0, spin});
		s = '0;
		unique case (p)
			2'd0: begin
				unique case (idx)
					3'd0:    s = 11'sd256;
					3'd1:    s = -11'sd256;
					3'd2:    s = 11'sd256;
					3'd3:    s = '0;
					default: s = sp;
				endcase
			end
			2'd1: begin
				unique case (idx)
					3'd0:    s = -11'sd128;
					3'd1:    s = 11'sd256;
					3'd3:    s = sp;
					default: s = '0;
				endcase
			end
			default: begin
				if (idx == 3'd0) s = -sp;
				else if (idx == 3'd1) s = sp;
			end
		endcase
		return s;
	endfunction

endpackage

// ===== sv/wps_cfg.sv =====
// Configuration register file of the wash program sequencer.
module wps_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_index,
	input  logic [wps_pkg::CFG_BITS-1:0]  cfg_wdata,
	output wps_pkg::cfg_t                 cfg
);

	wps_pkg::cfg_t cfg_q;

	// Write the addressed register; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_increment_ms <= wps_pkg::TICK_INC_RST;
			cfg_q.spin_low_speed    <= wps_pkg::SPIN_LOW_RST;
			cfg_q.spin_high_speed   <= wps_pkg::SPIN_HIGH_RST;
		end else if (cfg_we) begin
			if (cfg_index == wps_pkg::REG_TICK_INC) cfg_q.tick_increment_ms <= cfg_wdata;
			if (cfg_index == wps_pkg::REG_SPIN_LOW) cfg_q.spin_low_speed <= cfg_wdata;
			if (cfg_index == wps_pkg::REG_SPIN_HIGH) cfg_q.spin_high_speed <= cfg_wdata;
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/wps_in_reg.sv =====
// Input register stage: captures one button item and hands it to the core.
module wps_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	input  logic          out_free,
	output logic          advance,
	output wps_pkg::btn_t btn_s1
);

	logic valid_s1;

	// Move the held item on when the result register can take it
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Hold the payload; bits 7:6 are padding
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			btn_s1 <= wps_pkg::btn_t'(s_tdata[5:0]);
		end
	end

endmodule

// ===== sv/wps_core.sv =====
// Sequencer state and next-state logic: each item that moves on updates the state.
module wps_core #(
	parameter int TIMER_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  wps_pkg::btn_t btn_s1,
	input  wps_pkg::cfg_t cfg,
	output wps_pkg::res_t res
);

	logic [3:0]            mode_q, mode_n;
	logic [1:0]            prog_q, prog_n;
	logic                  spin_q, spin_n;
	logic [2:0]            step_q, step_n;
	logic [TIMER_BITS-1:0] timer_q, timer_n;
	logic signed [10:0]    setp_q, setp_n;
	logic [7:0]            led_q, led_n;

	logic [1:0]                     own;
	logic [1:0]                     p;
	logic [2:0]                     len;
	logic [2:0]                     step_inc;
	logic [TIMER_BITS-1:0]          timer_sum;
	logic [wps_pkg::CFG_BITS-1:0]   spin_spd;

	assign own       = mode_q[1:0];
	assign p         = 2'(mode_q - wps_pkg::MODE_RUN1);
	assign len       = wps_pkg::prog_len(p);
	assign step_inc  = step_q + 3'd1;
	assign timer_sum = timer_q + TIMER_BITS'(cfg.tick_increment_ms);
	assign spin_spd  = spin_q ? cfg.spin_high_speed : cfg.spin_low_speed;

	// Next state for the item at the input register
	always_comb begin
		mode_n  = mode_q;
		prog_n  = prog_q;
		spin_n  = spin_q;
		step_n  = step_q;
		timer_n = timer_q;
		setp_n  = setp_q;
		led_n   = led_q;
		unique case (mode_q)
			wps_pkg::MODE_SEL1, wps_pkg::MODE_SEL2, wps_pkg::MODE_SEL3: begin
				led_n[5:0] = {own == 2'd3, own == 2'd2, own == 2'd1, 3'b000};
				if (btn_s1.start) mode_n = mode_q + wps_pkg::MODE_STRIDE;
				if (btn_s1.spin_off) begin
					led_n[7:6] = wps_pkg::LED_SPIN_LOW;
					spin_n     = 1'b0;
				end
				if (btn_s1.spin_on) begin
					led_n[7:6] = wps_pkg::LED_SPIN_HIGH;
					spin_n     = 1'b1;
				end
				// Program change wins over start
				unique case (own)
					2'd1: begin
						if (btn_s1.prog_two) begin
							prog_n = 2'd2; mode_n = wps_pkg::MODE_SEL2;
						end else if (btn_s1.prog_three) begin
							prog_n = 2'd3; mode_n = wps_pkg::MODE_SEL3;
						end
					end
					2'd2: begin
						if (btn_s1.prog_one) begin
							prog_n = 2'd1; mode_n = wps_pkg::MODE_SEL1;
						end else if (btn_s1.prog_three) begin
							prog_n = 2'd3; mode_n = wps_pkg::MODE_SEL3;
						end
					end
					default: begin
						if (btn_s1.prog_one) begin
							prog_n = 2'd1; mode_n = wps_pkg::MODE_SEL1;
						end else if (btn_s1.prog_two) begin
							prog_n = 2'd2; mode_n = wps_pkg::MODE_SEL2;
						end
					end
				endcase
			end
			wps_pkg::MODE_ARM1, wps_pkg::MODE_ARM2, wps_pkg::MODE_ARM3: begin
				// Run on release of start
				if (!btn_s1.start) begin
					step_n  = '0;
					timer_n = '0;
					mode_n  = mode_q + wps_pkg::MODE_STRIDE;
				end
			end
			wps_pkg::MODE_RUN1, wps_pkg::MODE_RUN2, wps_pkg::MODE_RUN3: begin
				if (btn_s1.start || step_q >= len) begin
					mode_n = wps_pkg::MODE_IDLE;
				end else begin
					setp_n  = wps_pkg::step_speed(p, step_q, spin_spd);
					timer_n = timer_sum;
					if (timer_sum > TIMER_BITS'(wps_pkg::step_dur(p, step_q))) begin
						timer_n = '0;
						step_n  = step_inc;
						if (step_inc == len) mode_n = wps_pkg::MODE_IDLE;
					end
				end
			end
			default: begin
				mode_n     = wps_pkg::MODE_IDLE;
				led_n[5:0] = '0;
				step_n     = '0;
				timer_n    = '0;
				setp_n     = '0;
				if (btn_s1.prog_two) begin
					prog_n = 2'd2; mode_n = wps_pkg::MODE_SEL2;
				end else if (btn_s1.prog_three) begin
					prog_n = 2'd3; mode_n = wps_pkg::MODE_SEL3;
				end else if (btn_s1.prog_one) begin
					prog_n = 2'd1; mode_n = wps_pkg::MODE_SEL1;
				end
			end
		endcase
	end

	// Commit the state when the item moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= wps_pkg::MODE_IDLE;
			prog_q  <= 2'd1;
			spin_q  <= 1'b0;
			step_q  <= '0;
			timer_q <= '0;
			setp_q  <= '0;
			led_q   <= '0;
		end else if (advance) begin
			mode_q  <= mode_n;
			prog_q  <= prog_n;
			spin_q  <= spin_n;
			step_q  <= step_n;
			timer_q <= timer_n;
			setp_q  <= setp_n;
			led_q   <= led_n;
		end
	end

	assign res.speed_setpoint = setp_n;
	assign res.led_pattern    = led_n;
	assign res.program_shown  = prog_n;
	assign res.step_shown     = step_n;
	assign res.mode_shown     = mode_n;

	// Mode stays within its ten codes
	a_mode_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= wps_pkg::MODE_RUN3)
		else $error("mode out of range");

	// Selected program is always 1 to 3
	a_prog_range: assert property (@(posedge clk) disable iff (!arst_n)
		prog_q != 2'd0)
		else $error("program selection zero");

	// A run never sits past its last step
	a_step_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q >= wps_pkg::MODE_RUN1) |-> (step_q < len))
		else $error("step beyond program length");

	// Idle clears the setpoint
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && mode_q == wps_pkg::MODE_IDLE) |=> (setp_q == 11'sd0))
		else $error("setpoint not cleared in idle");

endmodule

// ===== sv/wash_program_sequencer_top.sv =====
// Top level of the wash program sequencer: input stage, core, config and result register.
//
// Usage: each item on the s_ channel is one timer tick carrying six button
// levels. For every accepted item exactly one result item leaves on the m_
// channel, holding the setpoint, LED byte, program, step and mode after that
// tick's update. Configuration registers (tick increment, low and high spin
// speed) are written through cfg_we/cfg_index/cfg_wdata, by the user only while
// the block idles; the block itself does not enforce this.
// Path: an accepted item goes through the input register, then the result register.
// Throughput: one item per cycle while m_tready stays high; the state update is a
// single pass of logic between the input register and the result register.
// Stall: while m_tready is low the result register holds; the input register
// still takes one item if it is empty, then s_tready drops until the result is taken.
// Reset: arst_n clears the mode to idle, program 1, spin off, step, timer,
// setpoint and LEDs to zero, and the config registers to 50 ms, 717, 819.
module wash_program_sequencer_top #(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [0] start_button, [1] prog_one_button, [2] prog_two_button,
	// [3] prog_three_button, [4] spin_off_button, [5] spin_on_button, [7:6] zero
	input  logic [7:0]  s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [10:0] speed_setpoint, [18:11] led_pattern, [20:19] program_shown,
	// [23:21] step_shown, [27:24] mode_shown, [31:28] zero
	output logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_wdata
);

	wps_pkg::btn_t btn_s1;
	wps_pkg::cfg_t cfg;
	wps_pkg::res_t res;
	wps_pkg::res_t res_q;
	logic          advance;
	logic          out_free;
	logic          out_valid_q;

	assign out_free = !out_valid_q || m_tready;

	wps_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	wps_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.out_free (out_free),
		.advance  (advance),
		.btn_s1   (btn_s1)
	);

	wps_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.btn_s1  (btn_s1),
		.cfg     (cfg),
		.res     (res)
	);

	// Result register: load on advance, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, res_q};

endmodule

// ===== tb/tb_wash_program_sequencer_top.sv =====
// Self-checking testbench for the wash program sequencer: button ticks in, panel status out.
`timescale 1ns / 1ps

module tb_wash_program_sequencer_top;

	// Marks in the speed table for steps that take the configured spin speed
	localparam int SPEED_SPIN_FWD = 4096;
	localparam int SPEED_SPIN_REV = -4096;

	// Program LED bits within led_pattern[5:0]
	localparam logic [5:0] LED_PROG_ONE   = 6'h08;
	localparam logic [5:0] LED_PROG_TWO   = 6'h10;
	localparam logic [5:0] LED_PROG_THREE = 6'h20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = wps_pkg::REG_TICK_INC;
	logic [9:0]  cfg_wdata = '0;

	wash_program_sequencer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// Button ticks waiting to be sent, and panel status still owed by the block
	wps_pkg::btn_t button_ticks[$];
	wps_pkg::res_t expected_status[$];
	int   err_count = 0;
	logic s_taken = 1'b0;

	// Sender burst/gap and receiver stall bookkeeping
	int       burst_left = 0;
	int       gap_left = 0;
	int       rdy_kind = 0;
	int       rdy_left = 0;
	bit [7:0] rdy_mask = '0;

	// Sequencer model state and its copy of the registers
	logic [3:0]         cur_mode = wps_pkg::MODE_IDLE;
	logic [1:0]         cur_prog = 2'd1;
	logic               spin_high_sel = 1'b0;
	logic [2:0]         cur_step = '0;
	logic [15:0]        step_clock = '0;
	logic signed [10:0] cur_speed = '0;
	logic [7:0]         led_bits = '0;
	logic [9:0]         cfg_tick = wps_pkg::TICK_INC_RST;
	logic [9:0]         cfg_spin_lo = wps_pkg::SPIN_LOW_RST;
	logic [9:0]         cfg_spin_hi = wps_pkg::SPIN_HIGH_RST;

	initial forever #5 clk = ~clk;

	function automatic logic [2:0] steps_in(input logic [1:0] p);
		case (p)
			2'd0:    return 3'd5;
			2'd1:    return 3'd4;
			default: return 3'd2;
		endcase
	endfunction

	function automatic int step_limit_ms(input logic [1:0] p, input logic [2:0] idx);
		case ({p, idx})
			{2'd0, 3'd0}, {2'd0, 3'd1}, {2'd0, 3'd2}, {2'd0, 3'd3}: return 4000;
			{2'd0, 3'd4}: return 10000;
			{2'd1, 3'd0}, {2'd1, 3'd2}: return 2000;
			{2'd1, 3'd1}: return 4000;
			{2'd1, 3'd3}: return 6000;
			{2'd2, 3'd0}, {2'd2, 3'd1}: return 3000;
			default: return 0;
		endcase
	endfunction

	function automatic int step_target(input logic [1:0] p, input logic [2:0] idx);
		case ({p, idx})
			{2'd0, 3'd0}, {2'd0, 3'd2}, {2'd1, 3'd1}: return 256;
			{2'd0, 3'd1}: return -256;
			{2'd1, 3'd0}: return -128;
			{2'd0, 3'd4}, {2'd1, 3'd3}, {2'd2, 3'd1}: return SPEED_SPIN_FWD;
			{2'd2, 3'd0}: return SPEED_SPIN_REV;
			default: return 0;
		endcase
	endfunction

	// Advance the sequencer model by one tick and return the panel status after it
	function automatic wps_pkg::res_t next_status(input wps_pkg::btn_t b);
		wps_pkg::res_t r;
		logic [3:0] own;
		logic [1:0] p;
		int spd;
		int spin;
		case (cur_mode)
			wps_pkg::MODE_SEL1, wps_pkg::MODE_SEL2, wps_pkg::MODE_SEL3: begin
				own = cur_mode;
				case (own)
					wps_pkg::MODE_SEL1: led_bits[5:0] = LED_PROG_ONE;
					wps_pkg::MODE_SEL2: led_bits[5:0] = LED_PROG_TWO;
					default:            led_bits[5:0] = LED_PROG_THREE;
				endcase
				if (b.start)
					cur_mode = own + wps_pkg::MODE_STRIDE;
				if (b.spin_off) begin
					led_bits[7:6] = wps_pkg::LED_SPIN_LOW;
					spin_high_sel = 1'b0;
				end
				if (b.spin_on) begin
					led_bits[7:6] = wps_pkg::LED_SPIN_HIGH;
					spin_high_sel = 1'b1;
				end
				// Another program's button wins over start
				case (own)
					wps_pkg::MODE_SEL1: begin
						if (b.prog_two) begin
							cur_prog = 2'd2; cur_mode = wps_pkg::MODE_SEL2;
						end else if (b.prog_three) begin
							cur_prog = 2'd3; cur_mode = wps_pkg::MODE_SEL3;
						end
					end
					wps_pkg::MODE_SEL2: begin
						if (b.prog_one) begin
							cur_prog = 2'd1; cur_mode = wps_pkg::MODE_SEL1;
						end else if (b.prog_three) begin
							cur_prog = 2'd3; cur_mode = wps_pkg::MODE_SEL3;
						end
					end
					default: begin
						if (b.prog_one) begin
							cur_prog = 2'd1; cur_mode = wps_pkg::MODE_SEL1;
						end else if (b.prog_two) begin
							cur_prog = 2'd2; cur_mode = wps_pkg::MODE_SEL2;
						end
					end
				endcase
			end
			wps_pkg::MODE_ARM1, wps_pkg::MODE_ARM2, wps_pkg::MODE_ARM3: begin
				// Start the run once start is released
				if (!b.start) begin
					cur_step = '0;
					step_clock = '0;
					cur_mode = cur_mode + wps_pkg::MODE_STRIDE;
				end
			end
			wps_pkg::MODE_RUN1, wps_pkg::MODE_RUN2, wps_pkg::MODE_RUN3: begin
				p = 2'(cur_mode - wps_pkg::MODE_RUN1);
				if (b.start || cur_step >= steps_in(p)) begin
					cur_mode = wps_pkg::MODE_IDLE;
				end else begin
					spin = spin_high_sel ? int'(cfg_spin_hi) : int'(cfg_spin_lo);
					spd = step_target(p, cur_step);
					if (spd == SPEED_SPIN_FWD)
						spd = spin;
					else if (spd == SPEED_SPIN_REV)
						spd = -spin;
					cur_speed = 11'(spd);
					step_clock = step_clock + {6'b0, cfg_tick};
					if (int'(step_clock) > step_limit_ms(p, cur_step)) begin
						step_clock = '0;
						cur_step = cur_step + 3'd1;
						if (cur_step == steps_in(p))
							cur_mode = wps_pkg::MODE_IDLE;
					end
				end
			end
			default: begin
				// Idle: clear program LEDs and the run, keep spin LEDs
				cur_mode = wps_pkg::MODE_IDLE;
				led_bits[5:0] = '0;
				cur_step = '0;
				step_clock = '0;
				cur_speed = '0;
				if (b.prog_two) begin
					cur_prog = 2'd2; cur_mode = wps_pkg::MODE_SEL2;
				end else if (b.prog_three) begin
					cur_prog = 2'd3; cur_mode = wps_pkg::MODE_SEL3;
				end else if (b.prog_one) begin
					cur_prog = 2'd1; cur_mode = wps_pkg::MODE_SEL1;
				end
			end
		endcase
		r.speed_setpoint = cur_speed;
		r.led_pattern = led_bits;
		r.program_shown = cur_prog;
		r.step_shown = cur_step;
		r.mode_shown = cur_mode;
		return r;
	endfunction

	task automatic check_status(input wps_pkg::res_t got);
		wps_pkg::res_t want;
		if (expected_status.size() == 0) begin
			if (err_count < 10)
				$display("unexpected status item: spd %0d led %02h prog %0d step %0d mode %0d",
					got.speed_setpoint, got.led_pattern, got.program_shown,
					got.step_shown, got.mode_shown);
			err_count++;
		end else begin
			want = expected_status.pop_front();
			if (got.speed_setpoint !== want.speed_setpoint
					|| got.led_pattern !== want.led_pattern
					|| got.program_shown !== want.program_shown
					|| got.step_shown !== want.step_shown
					|| got.mode_shown !== want.mode_shown) begin
				if (err_count < 10)
					$display({"status mismatch at %0t: ",
						"exp spd %0d led %02h prog %0d step %0d mode %0d, ",
						"got spd %0d led %02h prog %0d step %0d mode %0d"},
						$realtime, want.speed_setpoint, want.led_pattern,
						want.program_shown, want.step_shown, want.mode_shown,
						got.speed_setpoint, got.led_pattern,
						got.program_shown, got.step_shown, got.mode_shown);
				err_count++;
			end
		end
	endtask

	// Monitor: predict on each accepted tick, check each accepted status item
	always @(posedge clk) begin
		if (arst_n) begin
			s_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				expected_status.push_back(next_status(wps_pkg::btn_t'(s_tdata[5:0])));
			if (m_tvalid && m_tready)
				check_status(wps_pkg::res_t'(m_tdata[27:0]));
		end
	end

	// Driver: send ticks in bursts with gaps, stall the result side on its own pattern
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || s_taken)) begin
			if (gap_left > 0 || button_ticks.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= {2'b00, button_ticks.pop_front()};
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 32);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end
		end
		if (rdy_left == 0) begin
			rdy_kind = $urandom_range(0, 2);
			rdy_left = $urandom_range(5, 60);
			rdy_mask = 8'($urandom);
		end
		rdy_left--;
		case (rdy_kind)
			0:       m_tready <= 1'b1;
			1:       m_tready <= rdy_mask[rdy_left % 8];
			default: m_tready <= (rdy_left % 7 == 0);
		endcase
	end

	function automatic wps_pkg::btn_t buttons(input bit st, input bit p1, input bit p2,
			input bit p3, input bit soff, input bit son);
		wps_pkg::btn_t b;
		b.start = st;
		b.prog_one = p1;
		b.prog_two = p2;
		b.prog_three = p3;
		b.spin_off = soff;
		b.spin_on = son;
		return b;
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			wps_pkg::REG_TICK_INC:  cfg_tick = val;
			wps_pkg::REG_SPIN_LOW:  cfg_spin_lo = val;
			wps_pkg::REG_SPIN_HIGH: cfg_spin_hi = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every tick is sent and every status item is back, then settle
	task automatic wait_idle();
		do
			@(posedge clk);
		while (button_ticks.size() != 0 || s_tvalid || expected_status.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Queue one user session: pick a program, maybe choose spin, start, run, maybe abort
	task automatic queue_wash_cycle(input int run_max);
		wps_pkg::btn_t b;
		int n;
		// stray button noise
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 4))
				button_ticks.push_back(wps_pkg::btn_t'(6'($urandom_range(0, 63))));
		b = '0;
		case ($urandom_range(0, 2))
			0:       b.prog_one = 1'b1;
			1:       b.prog_two = 1'b1;
			default: b.prog_three = 1'b1;
		endcase
		b.start = ($urandom_range(0, 4) == 0);
		button_ticks.push_back(b);
		// spin choice, sometimes mixed with another program press
		n = $urandom_range(0, 3);
		repeat (n) begin
			b = '0;
			case ($urandom_range(0, 2))
				0:       b.spin_off = 1'b1;
				1:       b.spin_on = 1'b1;
				default: begin b.spin_off = 1'b1; b.spin_on = 1'b1; end
			endcase
			if ($urandom_range(0, 4) == 0)
				b[3:1] = 3'($urandom_range(0, 7));
			button_ticks.push_back(b);
		end
		// broken session: never started
		if ($urandom_range(0, 9) == 0)
			return;
		repeat ($urandom_range(1, 3)) begin
			b = wps_pkg::btn_t'(6'($urandom_range(0, 63)));
			if ($urandom_range(0, 2) != 0)
				b = '0;
			b.start = 1'b1;
			button_ticks.push_back(b);
		end
		// run ticks; other buttons are ignored while running
		n = $urandom_range(1, run_max);
		repeat (n) begin
			b = '0;
			if ($urandom_range(0, 4) == 0)
				b = wps_pkg::btn_t'(6'($urandom_range(0, 63)) & 6'h3E);
			button_ticks.push_back(b);
		end
		if ($urandom_range(0, 1) == 0)
			button_ticks.push_back(buttons(1, 0, 0, 0, 0, 0));
		repeat ($urandom_range(0, 2)) button_ticks.push_back('0);
	endtask

	task automatic random_phase(input int n_ticks, input int run_max);
		int base;
		base = button_ticks.size();
		while (button_ticks.size() - base < n_ticks)
			queue_wash_cycle(run_max);
		wait_idle();
	endtask

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed part at reset register values
		button_ticks.push_back('0);
		button_ticks.push_back(buttons(1, 1, 1, 1, 1, 1));  // all pressed while idle
		button_ticks.push_back('0);
		button_ticks.push_back(buttons(0, 0, 0, 0, 1, 1));  // both spin buttons
		button_ticks.push_back(buttons(1, 1, 0, 0, 0, 0));  // start with program change
		button_ticks.push_back(buttons(0, 0, 0, 1, 0, 0));
		button_ticks.push_back(buttons(1, 0, 0, 0, 0, 0));  // arm program three
		button_ticks.push_back(buttons(1, 1, 1, 0, 1, 1));  // held start, others ignored
		button_ticks.push_back('0);                        // released: run
		button_ticks.push_back('0);
		button_ticks.push_back(buttons(0, 1, 1, 1, 1, 1));
		button_ticks.push_back(buttons(1, 0, 0, 0, 0, 0));  // abort
		button_ticks.push_back('0);
		button_ticks.push_back(buttons(0, 1, 0, 0, 0, 0));
		button_ticks.push_back(buttons(0, 0, 0, 0, 1, 0));  // spin low
		button_ticks.push_back(buttons(1, 0, 0, 0, 0, 0));
		button_ticks.push_back('0);
		button_ticks.push_back('0);
		button_ticks.push_back('0);
		button_ticks.push_back(buttons(1, 0, 0, 0, 0, 0));
		button_ticks.push_back(buttons(0, 0, 1, 0, 0, 0));
		button_ticks.push_back(buttons(1, 0, 0, 0, 0, 0));
		button_ticks.push_back('0);
		button_ticks.push_back('0);
		button_ticks.push_back(buttons(1, 0, 0, 0, 0, 0));
		wait_idle();

		// Random sessions across register settings, extremes first
		write_reg(wps_pkg::REG_TICK_INC, 10'd1000);
		write_reg(wps_pkg::REG_SPIN_LOW, 10'd0);
		write_reg(wps_pkg::REG_SPIN_HIGH, 10'd1023);
		random_phase(120, 40);

		write_reg(wps_pkg::REG_TICK_INC, 10'd1);
		write_reg(wps_pkg::REG_SPIN_LOW, 10'd1023);
		write_reg(wps_pkg::REG_SPIN_HIGH, 10'd0);
		random_phase(110, 20);

		// zero increment: runs only end by abort
		write_reg(wps_pkg::REG_TICK_INC, 10'd0);
		write_reg(wps_pkg::REG_SPIN_LOW, 10'($urandom));
		write_reg(wps_pkg::REG_SPIN_HIGH, 10'($urandom));
		random_phase(100, 20);

		write_reg(wps_pkg::REG_TICK_INC, 10'($urandom_range(600, 1000)));
		write_reg(wps_pkg::REG_SPIN_LOW, 10'($urandom));
		write_reg(wps_pkg::REG_SPIN_HIGH, 10'($urandom));
		random_phase(140, 70);

		write_reg(wps_pkg::REG_TICK_INC, 10'd500);
		write_reg(wps_pkg::REG_SPIN_LOW, wps_pkg::SPIN_LOW_RST);
		write_reg(wps_pkg::REG_SPIN_HIGH, wps_pkg::SPIN_HIGH_RST);
		random_phase(130, 70);

		if (err_count == 0 && expected_status.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/wps_pkg.sv
sv/wps_cfg.sv
sv/wps_in_reg.sv
sv/wps_core.sv
sv/wash_program_sequencer_top.sv
tb/tb_wash_program_sequencer_top.sv
